// ===== design/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by the controller, the datapath and the checker.
`timescale 1ns / 1ps

package sitd_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // shift-and-add-3 binary to BCD: correct a digit of 5 or more before each shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    typedef struct packed {
        logic start;       // load a new value
        logic conv;        // one binary to BCD step
        logic find;        // locate the leading nonzero digit
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the current digit into the output register
    } t_cmd;

    typedef struct packed {
        logic conv_done;   // this conversion step is the final one
        logic neg;         // value is negative
        logic last_digit;  // digit pointer at the least significant digit
        logic out_free;    // output register can take a character this cycle
    } t_sts;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Instantiates sitd_ctrl and sitd_datapath; depends on sitd_pkg.
//
// Each accepted value (low VALUE_WIDTH bits, two's complement) comes out as
// its decimal text, one character per output transfer, most significant
// first: '-' for negatives, then digits without leading zeros; o_last marks
// the final character. The most negative value converts correctly. One value
// is in work at a time: after the input transfer the shift-and-add-3 BCD
// converter takes in one bit per cycle until all VALUE_WIDTH bits are in, the
// leading digit is found next, then one character leaves per cycle while the
// output is not stalled. The last character may still wait in the output
// register while the next value is accepted.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_char_code,
    output logic        o_last
);
    import sitd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sitd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sitd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ===== design/sitd_ctrl.sv =====
// Sequencer for the converter: accept, convert, find the leading digit, emit.
// Depends on sitd_pkg for the command and status structs.
`timescale 1ns / 1ps

module sitd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sitd_pkg::t_sts i_sts,
    output sitd_pkg::t_cmd o_cmd
);
    import sitd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = i_sts.neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/sitd_datapath.sv =====
// Datapath: magnitude register, shift-and-add-3 BCD converter, digit pointer
// and output register. Depends on sitd_pkg.
`timescale 1ns / 1ps

module sitd_datapath #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sitd_pkg::t_cmd i_cmd,
    output sitd_pkg::t_sts o_sts,
    input  logic [63:0]    i_value,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_char_code,
    output logic           o_last
);
    import sitd_pkg::*;

    // decimal digits of 2^VALUE_WIDTH, enough for 2^(VALUE_WIDTH-1): floor(W*log10(2)) + 1
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCDW = NDIG * 4;
    localparam int IDXW = $clog2(NDIG);
    localparam int CNTW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCDW-1:0]        r_bcd;
    logic                   r_neg;
    logic [CNTW-1:0]        r_cnt;
    logic [IDXW-1:0]        r_idx;
    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic [BCDW-1:0]        bcd_adj;
    logic [IDXW-1:0]        lead_idx;
    logic [3:0]             cur_digit;
    logic                   out_free;

    assign raw   = i_value[VALUE_WIDTH-1:0];
    assign n_mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= BCD_ADJ_LIMIT)
                              ? r_bcd[d*4 +: 4] + BCD_ADJ : r_bcd[d*4 +: 4];
        end
    end

    // highest nonzero digit wins; all zero leaves the units digit
    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                lead_idx = IDXW'(d);
            end
        end
    end

    assign cur_digit = r_bcd[r_idx*4 +: 4];
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mag <= n_mag;
            r_neg <= raw[VALUE_WIDTH-1];
            r_bcd <= '0;
            r_cnt <= CNTW'(VALUE_WIDTH - 1);
        end else if (i_cmd.conv) begin
            r_bcd <= {bcd_adj[BCDW-2:0], r_mag[VALUE_WIDTH-1]};
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - CNTW'(1);
        end
        if (i_cmd.find) begin
            r_idx <= lead_idx;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - IDXW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {4'd0, cur_digit};
            r_last <= (r_idx == '0);
        end
    end

    assign o_sts.conv_done  = (r_cnt == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.last_digit = (r_idx == '0);
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ===== design/sitd_checker.sv =====
// Port-level checks for the converter, bound to the top level.
// Depends on sitd_pkg for the character codes.
`timescale 1ns / 1ps

module sitd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_char_code,
    input logic        o_last
);
    import sitd_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_char_code) && $stable(o_last))
        else $error("output character changed while stalled");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_code == CHAR_MINUS) ||
                        (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_ZERO + 8'd9))
        else $error("character outside '-' and digits");

    // the sign is never marked as the last character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_code == CHAR_MINUS |-> !o_last)
        else $error("sign marked as last character");

    // one value at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before conversion");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (.*);

// ===== sim/signed_int_to_decimal_ascii_test.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: feeds 64-bit values, predicts
// their decimal ASCII text and checks every character transfer. Needs sitd_pkg.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;
    import sitd_pkg::*;

    localparam int VALUE_WIDTH  = 64;
    localparam int RANDOM_ITEMS = 188;
    localparam int HOLD_AT      = 30;    // values sent before the long receiver hold
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_value = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_char_code;
    logic        o_last;

    logic [63:0] pending_values[$];
    t_char       expected_chars[$];
    int          values_sent = 0;
    int          total_values = 1;
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    signed_int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (in_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTS)
            $display("ERROR %0t: %s", $time, msg);
        errors++;
    endtask

    // Queue the characters one value turns into.
    function automatic void decimal_text(input logic [63:0] value);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic        negative;
        logic [7:0]  digits[$];
        t_char       ch;
        mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        raw = value & mask;
        negative = raw[VALUE_WIDTH - 1];
        mag = negative ? ((~raw + 64'd1) & mask) : raw;
        do begin
            digits.push_front(CHAR_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        if (negative) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        while (digits.size() > 0) begin
            ch.code = digits.pop_front();
            ch.last = (digits.size() == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // Mostly values of random bit length, plus fully random and small values, powers of ten and the ends of the range.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          kind;
        int          n;
        v = {$urandom, $urandom};
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                n = $urandom_range(1, 63);
                v = v & ((64'd1 << n) - 64'd1);
            end
            6: begin
                p = 64'd1;
                n = $urandom_range(0, 18);
                repeat (n) p = p * 64'd10;
                v = p - 64'($urandom_range(1));
            end
            7: ;
            8: v = 64'($urandom_range(20));
            default: begin
                if ($urandom_range(1))
                    v = 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
                else
                    v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
            end
        endcase
        if (kind <= 8 && kind != 7 && $urandom_range(1))
            v = -v;
        return v;
    endfunction

    // idle percentage per side: sender first light, then heavy, then none
    function automatic int idle_pct(input int sent, input logic sender);
        int phase;
        phase = sent * 3 / total_values;
        case (phase)
            0:       return sender ? 18 : 53;
            1:       return sender ? 53 : 18;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                decimal_text(in_value);
                values_sent <= values_sent + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_values.size() > 0
                        && $urandom_range(99) >= idle_pct(values_sent, 1'b1)) begin
                    in_value <= pending_values.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, receiver stall and idle counter
    always @(posedge i_clk) begin : monitor
        t_char want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_error($sformatf("char 0x%02h with no value pending", o_char_code));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.code)
                        report_error($sformatf("char_code 0x%02h, want 0x%02h",
                                               o_char_code, want.code));
                    if (o_last !== want.last)
                        report_error($sformatf("last %b, want %b", o_last, want.last));
                end
            end

            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            // one long hold so the block backs up and stalls its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && values_sent >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < idle_pct(values_sent, 1'b0));
            end
        end
    end

    initial begin
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(-64'd1);
        pending_values.push_back(64'd9);
        pending_values.push_back(-64'd9);
        pending_values.push_back(64'd10);
        pending_values.push_back(-64'd10);
        pending_values.push_back(64'd99);
        pending_values.push_back(64'd100);
        pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'h8000_0000_0000_0000);
        pending_values.push_back(64'h8000_0000_0000_0001);
        pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFE);
        pending_values.push_back(64'd1000000000000000000);
        pending_values.push_back(64'd999999999999999999);
        pending_values.push_back(-64'd1000000000000000000);
        pending_values.push_back(64'd1234567890123456789);
        pending_values.push_back(-64'd987654321);
        pending_values.push_back(64'h5555_5555_5555_5555);
        pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_values.push_back(64'd7);
        pending_values.push_back(64'd0);
        repeat (RANDOM_ITEMS) pending_values.push_back(random_value());
        total_values = pending_values.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while ((pending_values.size() > 0 || in_valid || expected_chars.size() > 0)
                && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);

        if (idle_cycles >= IDLE_LIMIT) begin
            report_error($sformatf("timeout, %0d values unsent, %0d chars outstanding",
                                   pending_values.size(), expected_chars.size()));
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (expected_chars.size() > 0)
                report_error($sformatf("%0d chars never arrived", expected_chars.size()));
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/sitd_pkg.sv
design/sitd_ctrl.sv
design/sitd_datapath.sv
design/signed_int_to_decimal_ascii.sv
design/sitd_checker.sv
sim/signed_int_to_decimal_ascii_test.sv
